@@ sv/attitude_strapdown_euler_unit_defines.svh @@
// Assertion macros for the attitude unit.
`ifndef ATTITUDE_STRAPDOWN_EULER_UNIT_DEFINES_SVH
`define ATTITUDE_STRAPDOWN_EULER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ASED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ased check failed");
`define ASED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ased check failed");
`else
`define ASED_ASSERT_IMP(lbl, ante, cons)
`define ASED_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/ased_pkg.sv @@
package ased_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 14;
  localparam int ATAN_LEN         = 24;
  localparam int AW               = 34;
  localparam int SCW              = 33;

  localparam logic [15:0] STEP_TIME_RST = 16'd6554;

  localparam logic signed [AW-1:0]  QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [AW-1:0]  HALF_TURN    = 34'sd2147483648;
  localparam logic signed [SCW-1:0] CORDIC_K     = 33'sd652032874;

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] prev_r00;
    logic signed [15:0] prev_r01;
    logic signed [15:0] prev_r02;
    logic signed [15:0] prev_r10;
    logic signed [15:0] prev_r11;
    logic signed [15:0] prev_r12;
    logic signed [15:0] prev_r20;
    logic signed [15:0] prev_r21;
    logic signed [15:0] prev_r22;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               gimbal_lock;
  } out_item_t;

  typedef struct packed {
    logic               gimbal;
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r01;
    logic signed [15:0] r11;
    logic signed [15:0] r02;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] gpitch;
  } side_a_t;

  typedef struct packed {
    side_a_t     a;
    logic [15:0] first_ang;
  } side_b_t;

  typedef struct packed {
    logic        gimbal;
    logic [15:0] first_ang;
  } side_r_t;

  function automatic logic signed [AW-1:0] atan_of(input int unsigned i);
    logic signed [AW-1:0] v;
    case (i)
      0:       v = 34'sd536870912;
      1:       v = 34'sd316933406;
      2:       v = 34'sd167458907;
      3:       v = 34'sd85004756;
      4:       v = 34'sd42667331;
      5:       v = 34'sd21354465;
      6:       v = 34'sd10679838;
      7:       v = 34'sd5340245;
      8:       v = 34'sd2670163;
      9:       v = 34'sd1335087;
      10:      v = 34'sd667544;
      11:      v = 34'sd333772;
      12:      v = 34'sd166886;
      13:      v = 34'sd83443;
      14:      v = 34'sd41722;
      15:      v = 34'sd20861;
      16:      v = 34'sd10430;
      17:      v = 34'sd5215;
      18:      v = 34'sd2608;
      19:      v = 34'sd1304;
      20:      v = 34'sd652;
      21:      v = 34'sd326;
      22:      v = 34'sd163;
      23:      v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] angle_out(input logic signed [AW-1:0] z);
    logic signed [AW-1:0] t;
    t = z + 34'sd32768;
    return t[31:16];
  endfunction

endpackage

@@ sv/attitude_strapdown_euler_unit.sv @@
// Throughput: one item per cycle; three unrolled CORDIC pipelines in series set the depth.
// busy is high during reset and in the cycle after it; otherwise every start is taken.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset clears valid bits and loads step_time with 6554.
`include "attitude_strapdown_euler_unit_defines.svh"
module attitude_strapdown_euler_unit #(
  parameter int CORDIC_STEPS = ased_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = ased_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                start,
  output logic                busy,
  input  ased_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ased_pkg::out_item_t out_data
);
  import ased_pkg::*;

  localparam int CW    = 50 - FRAC_BITS;
  localparam int UP_SH = 30 - FRAC_BITS;

  logic        busy_r;
  logic [15:0] step_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      step_time_r <= STEP_TIME_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        step_time_r <= cfg_wdata;
      end
    end
  end

  assign busy = busy_r;

  // stage 1: capture item
  logic     v1_r, v2_r, v3_r, v4_r;
  in_item_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start && !busy_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      in_r <= in_data;
    end
  end

  // stage 2: rate times step
  logic signed [15:0] p1 [3][3];
  logic signed [15:0] p2_r [3][3];
  logic signed [15:0] p3_r [3][3];
  logic signed [32:0] a_nxt [3];
  logic signed [32:0] a_r [3];
  logic signed [32:0] dt_s;

  assign dt_s = 33'($signed({1'b0, step_time_r}));
  assign a_nxt[0] = 33'(in_r.rate_x) * dt_s;
  assign a_nxt[1] = 33'(in_r.rate_y) * dt_s;
  assign a_nxt[2] = 33'(in_r.rate_z) * dt_s;

  assign p1[0][0] = in_r.prev_r00;
  assign p1[0][1] = in_r.prev_r01;
  assign p1[0][2] = in_r.prev_r02;
  assign p1[1][0] = in_r.prev_r10;
  assign p1[1][1] = in_r.prev_r11;
  assign p1[1][2] = in_r.prev_r12;
  assign p1[2][0] = in_r.prev_r20;
  assign p1[2][1] = in_r.prev_r21;
  assign p1[2][2] = in_r.prev_r22;

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    p2_r <= p1;
  end

  // stage 3: matrix products
  logic signed [32:0] s [3][3];
  logic signed [48:0] prod_r [3][3][3];

  always_comb begin
    s[0][0] = '0;     s[0][1] = -a_r[2]; s[0][2] = a_r[1];
    s[1][0] = a_r[2]; s[1][1] = '0;      s[1][2] = -a_r[0];
    s[2][0] = -a_r[1]; s[2][1] = a_r[0]; s[2][2] = '0;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[i][j][k] <= 49'(p2_r[i][k]) * 49'(s[k][j]);
        end
      end
    end
    p3_r <= p2_r;
  end

  // stage 4: round, add, saturate
  logic signed [15:0] r4_r [3][3];
  logic signed [50:0] acc [3][3];
  logic signed [50:0] sum [3][3];
  logic signed [15:0] r_nxt [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc[i][j] = 51'(prod_r[i][j][0]) + 51'(prod_r[i][j][1]) + 51'(prod_r[i][j][2])
                  + (51'sd1 <<< 27);
        sum[i][j] = (acc[i][j] >>> 28) + 51'(p3_r[i][j]);
        if (sum[i][j] > 51'sd32767) begin
          r_nxt[i][j] = 16'sh7fff;
        end else if (sum[i][j] < -51'sd32768) begin
          r_nxt[i][j] = 16'sh8000;
        end else begin
          r_nxt[i][j] = sum[i][j][15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    r4_r <= r_nxt;
  end

  // yaw vector (roll vector under gimbal lock)
  logic                 gimbal;
  logic signed [CW-1:0] vx1, vy1;
  logic signed [47:0]   pv, pq;
  logic signed [15:0]   gpitch;
  side_a_t              side_a;

  assign gimbal = (r4_r[0][0] == 0) && (r4_r[1][0] == 0);
  assign vy1 = gimbal ? (-CW'(r4_r[0][1])) <<< UP_SH : CW'(r4_r[1][0]) <<< UP_SH;
  assign vx1 = gimbal ? CW'(r4_r[1][1]) <<< UP_SH : CW'(r4_r[0][0]) <<< UP_SH;
  assign pv  = (-48'(r4_r[2][0])) <<< 14;
  assign pq  = (pv + (48'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_comb begin
    if (pq > 48'sd32767) begin
      gpitch = 16'sh7fff;
    end else if (pq < -48'sd32768) begin
      gpitch = 16'sh8000;
    end else begin
      gpitch = pq[15:0];
    end
  end

  always_comb begin
    side_a.gimbal = gimbal;
    side_a.r00    = r4_r[0][0];
    side_a.r10    = r4_r[1][0];
    side_a.r01    = r4_r[0][1];
    side_a.r11    = r4_r[1][1];
    side_a.r02    = r4_r[0][2];
    side_a.r12    = r4_r[1][2];
    side_a.r20    = r4_r[2][0];
    side_a.gpitch = gpitch;
  end

  logic                 v_y;
  logic signed [AW-1:0] z_y;
  side_a_t              side_ay;
  side_b_t              side_b, side_bo;

  ased_cordic_vec #(.STEPS(CORDIC_STEPS), .CW(CW), .SW($bits(side_a_t))) u_vec_yaw (
    .clk(clk), .rst_n(rst_n), .in_valid(v4_r), .x_in(vx1), .y_in(vy1),
    .side_in(side_a), .out_valid(v_y), .z_out(z_y), .side_out(side_ay)
  );

  assign side_b.a         = side_ay;
  assign side_b.first_ang = angle_out(z_y);

  logic                  v_sc;
  logic signed [SCW-1:0] sn, cs;

  ased_cordic_rot #(.STEPS(CORDIC_STEPS), .SW($bits(side_b_t))) u_rot (
    .clk(clk), .rst_n(rst_n), .in_valid(v_y), .z_in(z_y), .side_in(side_b),
    .out_valid(v_sc), .sin_out(sn), .cos_out(cs), .side_out(side_bo)
  );

  // rotate rows by yaw: products, then sums
  logic               v5_r, v6_r;
  logic signed [48:0] m_r [6];
  side_b_t            side5_r, side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v5_r <= v_sc;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    m_r[0]  <= 49'(side_bo.a.r00) * 49'(cs);
    m_r[1]  <= 49'(side_bo.a.r10) * 49'(sn);
    m_r[2]  <= 49'(side_bo.a.r02) * 49'(sn);
    m_r[3]  <= 49'(side_bo.a.r12) * 49'(cs);
    m_r[4]  <= 49'(side_bo.a.r01) * 49'(sn);
    m_r[5]  <= 49'(side_bo.a.r11) * 49'(cs);
    side5_r <= side_bo;
  end

  logic signed [49:0]   hs, nys, nxs;
  logic signed [CW-1:0] h6_r, ny6_r, nx6_r, yp6_r;

  assign hs  = (50'(m_r[0]) + 50'(m_r[1])) >>> FRAC_BITS;
  assign nys = (50'(m_r[2]) - 50'(m_r[3])) >>> FRAC_BITS;
  assign nxs = (50'(m_r[5]) - 50'(m_r[4])) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    h6_r    <= hs[CW-1:0];
    ny6_r   <= nys[CW-1:0];
    nx6_r   <= nxs[CW-1:0];
    yp6_r   <= CW'(side5_r.a.r20) <<< UP_SH;
    side6_r <= side5_r;
  end

  side_r_t              side_r_in, side_r_out;
  logic                 roll_v, pitch_v;
  logic signed [AW-1:0] z_roll, z_pitch;
  logic [15:0]          gp_out;

  assign side_r_in.gimbal    = side6_r.a.gimbal;
  assign side_r_in.first_ang = side6_r.first_ang;

  ased_cordic_vec #(.STEPS(CORDIC_STEPS), .CW(CW), .SW($bits(side_r_t))) u_vec_roll (
    .clk(clk), .rst_n(rst_n), .in_valid(v6_r), .x_in(nx6_r), .y_in(ny6_r),
    .side_in(side_r_in), .out_valid(roll_v), .z_out(z_roll), .side_out(side_r_out)
  );

  ased_cordic_vec #(.STEPS(CORDIC_STEPS), .CW(CW), .SW(16)) u_vec_pitch (
    .clk(clk), .rst_n(rst_n), .in_valid(v6_r), .x_in(h6_r), .y_in(yp6_r),
    .side_in(side6_r.a.gpitch), .out_valid(pitch_v), .z_out(z_pitch), .side_out(gp_out)
  );

  // output register
  logic      out_valid_r;
  out_item_t out_nxt, out_r;

  always_comb begin
    if (side_r_out.gimbal) begin
      out_nxt.roll_angle  = side_r_out.first_ang;
      out_nxt.pitch_angle = gp_out;
      out_nxt.yaw_angle   = '0;
      out_nxt.gimbal_lock = 1'b1;
    end else begin
      out_nxt.roll_angle  = angle_out(z_roll);
      out_nxt.pitch_angle = angle_out(-z_pitch);
      out_nxt.yaw_angle   = side_r_out.first_ang;
      out_nxt.gimbal_lock = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= roll_v;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASED_ASSERT_IMP(a_lanes_aligned, roll_v != pitch_v, 1'b0)
  `ASED_ASSERT_NXT(a_accept_enters, start && !busy, v1_r)
  `ASED_ASSERT_NXT(a_result_strobe, roll_v, out_valid)
  `ASED_ASSERT_IMP(a_gimbal_yaw, out_valid && out_data.gimbal_lock, out_data.yaw_angle == 0)

endmodule

@@ sv/ased_cordic_vec.sv @@
module ased_cordic_vec #(
  parameter int STEPS = ased_pkg::CORDIC_STEPS_DEF,
  parameter int CW    = 36,
  parameter int SW    = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [CW-1:0]         x_in,
  input  logic signed [CW-1:0]         y_in,
  input  logic [SW-1:0]                side_in,
  output logic                         out_valid,
  output logic signed [ased_pkg::AW-1:0] z_out,
  output logic [SW-1:0]                side_out
);
  import ased_pkg::*;

  logic                 v_r    [STEPS+1];
  logic                 zero_r [STEPS+1];
  logic signed [CW-1:0] x_r    [STEPS+1];
  logic signed [CW-1:0] y_r    [STEPS+1];
  logic signed [AW-1:0] z_r    [STEPS+1];
  logic [SW-1:0]        side_r [STEPS+1];

  logic signed [CW-1:0] x_nxt, y_nxt;
  logic signed [AW-1:0] z_nxt;

  always_comb begin
    x_nxt = x_in;
    y_nxt = y_in;
    z_nxt = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x_nxt = y_in;
        y_nxt = -x_in;
        z_nxt = QUARTER_TURN;
      end else begin
        x_nxt = -y_in;
        y_nxt = x_in;
        z_nxt = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= x_nxt;
    y_r[0]    <= y_nxt;
    z_r[0]    <= z_nxt;
    zero_r[0] <= (x_in == 0) && (y_in == 0);
    side_r[0] <= side_in;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    logic signed [CW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + atan_of(i);
      end else begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - atan_of(i);
      end
      zero_r[i+1] <= zero_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_valid = v_r[STEPS];
  assign z_out     = zero_r[STEPS] ? '0 : z_r[STEPS];
  assign side_out  = side_r[STEPS];

endmodule

@@ sv/ased_cordic_rot.sv @@
module ased_cordic_rot #(
  parameter int STEPS = ased_pkg::CORDIC_STEPS_DEF,
  parameter int SW    = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [ased_pkg::AW-1:0]  z_in,
  input  logic [SW-1:0]                 side_in,
  output logic                          out_valid,
  output logic signed [ased_pkg::SCW-1:0] sin_out,
  output logic signed [ased_pkg::SCW-1:0] cos_out,
  output logic [SW-1:0]                 side_out
);
  import ased_pkg::*;

  logic                  v_r    [STEPS+1];
  logic                  flip_r [STEPS+1];
  logic signed [SCW-1:0] x_r    [STEPS+1];
  logic signed [SCW-1:0] y_r    [STEPS+1];
  logic signed [AW-1:0]  z_r    [STEPS+1];
  logic [SW-1:0]         side_r [STEPS+1];

  logic signed [AW-1:0] z_nxt;
  logic                 flip_nxt;

  always_comb begin
    z_nxt    = z_in;
    flip_nxt = 1'b0;
    if (z_in > QUARTER_TURN) begin
      z_nxt    = z_in - HALF_TURN;
      flip_nxt = 1'b1;
    end else if (z_in < -QUARTER_TURN) begin
      z_nxt    = z_in + HALF_TURN;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= CORDIC_K;
    y_r[0]    <= '0;
    z_r[0]    <= z_nxt;
    flip_r[0] <= flip_nxt;
    side_r[0] <= side_in;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    logic signed [SCW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - atan_of(i);
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + atan_of(i);
      end
      flip_r[i+1] <= flip_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_valid = v_r[STEPS];
  assign sin_out   = flip_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
  assign cos_out   = flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
  assign side_out  = side_r[STEPS];

endmodule
